### src/fdpd_pkg.sv
// Package for the first-derivative peak detector: payload structs, FSM states,
// fixed constants and the divider request type. No dependencies.
`default_nettype none
package fdpd_pkg;

    localparam int unsigned INT_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned THR_W   = 41;
    localparam int unsigned WID_W   = 6;
    localparam int unsigned SLOPE_W = 48;
    localparam int unsigned Y_W     = 41;
    localparam int unsigned SUM_W   = 54;
    localparam int unsigned DIV_W   = 48;
    localparam int unsigned DIVC_W  = 6;
    localparam int unsigned PROD_W  = 49;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [16:0]        NORM_BASE   = 17'd100000;
    localparam logic [THR_W-1:0]   DEFAULT_THR = 41'd838861;
    localparam logic [WID_W-1:0]   DEFAULT_WID = 6'd5;
    localparam int unsigned        MIN_SAMPLES = 5;
    localparam int unsigned        MIN_SPAN    = 2;   // stop - start + 1 >= 3

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH    = 8'd1;

    typedef struct packed {
        logic [INT_W-1:0]  intensity;
        logic [TIME_W-1:0] retention_ms;
        logic              final_sample;
    } in_t;

    typedef struct packed {
        logic              peak_found;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] apex_ms;
        logic [TIME_W-1:0] stop_ms;
        logic              run_end;
        logic              truncated;
    } out_t;

    typedef struct packed {
        logic [31:0]      rem0;
        logic [DIV_W-1:0] num;
        logic [31:0]      den;
    } div_req_t;

    typedef enum logic [5:0] {
        ST_LOAD, ST_NRD, ST_NMUL, ST_NDIV, ST_NWAIT, ST_SDIV, ST_SWAIT,
        ST_SMSET, ST_ARD, ST_AADD, ST_MRD, ST_MCHK, ST_MWAIT, ST_URD, ST_UADD,
        ST_USUB, ST_SR0, ST_SR1, ST_SR2, ST_SR3, ST_SCHK, ST_XRD, ST_XCHK,
        ST_PRD, ST_PCHK, ST_REC, ST_T1, ST_T2, ST_T3, ST_EMIT, ST_ERD, ST_ELD,
        ST_EWAIT
    } state_t;

endpackage
`default_nettype wire

### src/fdpd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, DIV_W steps.
// Depends on fdpd_pkg.
`default_nettype none
module fdpd_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire fdpd_pkg::div_req_t        req,
    output logic                           done,
    output logic [fdpd_pkg::DIV_W-1:0]     quo
);
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [fdpd_pkg::DIVC_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]                    rem_reg, rem_next;
    logic [31:0]                    den_reg, den_next;
    logic [fdpd_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [32:0]                    trial;
    logic                           ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        trial     = {rem_reg, num_reg[fdpd_pkg::DIV_W-1]};
        ge        = trial >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.rem0;
            den_next  = req.den;
            num_next  = req.num;
        end else if (busy_reg) begin
            // quotient bits shift in where dividend bits shift out
            rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_next = {num_reg[fdpd_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fdpd_pkg::DIVC_W'(fdpd_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule
`default_nettype wire

### src/first_derivative_peak_detector.sv
// First-derivative peak detector: sample/slope stores, run sequencer, peak buffer.
// Depends on fdpd_pkg and fdpd_div.
//
// Samples load at one per cycle into on-chip stores until a transaction with
// final_sample set arrives; s_ready then drops while the run is processed.
// Each sample after the first costs two 48-step passes through the shared
// bit-serial divider (normalization, then slope); the first costs only the
// normalization pass. Smoothing adds one more divide per interior slope and a
// window preload; the peak scan reads the stored slopes one at a time, checking
// each window before moving on; each emitted peak passes through a read, a load
// and a wait for the consumer's ready. The divider and the single read port of
// each store set this pace. After the last result of a run is taken the block
// is ready for the next run. Runs under 5 samples yield only the end marker.
`default_nettype none
module first_derivative_peak_detector #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_WIDTH   = 45,
    parameter int unsigned MAX_PEAKS   = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire fdpd_pkg::in_t                     s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output fdpd_pkg::out_t                         m_data,
    input  wire logic                              cfg_we,
    input  wire logic [fdpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdpd_pkg::THR_W-1:0]        cfg_wdata
);
    localparam int unsigned AW    = $clog2(MAX_SAMPLES);
    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW    = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int unsigned FW    = $clog2(MAX_PEAKS + 1);
    localparam int unsigned SW    = fdpd_pkg::SLOPE_W;
    localparam int unsigned PK_W  = 3 * fdpd_pkg::TIME_W;

    // stores
    logic [fdpd_pkg::INT_W-1:0]  int_mem  [MAX_SAMPLES];
    logic [fdpd_pkg::TIME_W-1:0] time_mem [MAX_SAMPLES];
    logic signed [SW-1:0]        slope_mem[MAX_SAMPLES];
    logic signed [SW-1:0]        sm_mem   [MAX_SAMPLES];
    logic [PK_W-1:0]             peak_mem [MAX_PEAKS];

    logic                        samp_we;
    logic [AW-1:0]               samp_wa, samp_ra;
    logic [fdpd_pkg::INT_W-1:0]  int_q;
    logic [fdpd_pkg::TIME_W-1:0] time_q;
    logic                        slope_we, sm_we;
    logic [AW-1:0]               slope_wa, slope_ra, sm_wa;
    logic signed [SW-1:0]        slope_wd, sm_wd, slope_q, sm_q, sl_q;
    logic                        peak_we;
    logic [PW-1:0]               peak_wa, peak_ra;
    logic [PK_W-1:0]             peak_wd, peak_q;

    always_ff @(posedge aclk) begin
        if (samp_we) begin
            int_mem[samp_wa]  <= s_data.intensity;
            time_mem[samp_wa] <= s_data.retention_ms;
        end
        int_q  <= int_mem[samp_ra];
        time_q <= time_mem[samp_ra];
    end

    always_ff @(posedge aclk) begin
        if (slope_we) slope_mem[slope_wa] <= slope_wd;
        slope_q <= slope_mem[slope_ra];
    end

    // smoothed store shares the slope read address
    always_ff @(posedge aclk) begin
        if (sm_we) sm_mem[sm_wa] <= sm_wd;
        sm_q <= sm_mem[slope_ra];
    end

    always_ff @(posedge aclk) begin
        if (peak_we) peak_mem[peak_wa] <= peak_wd;
        peak_q <= peak_mem[peak_ra];
    end

    // divider
    logic                         div_start, div_done;
    fdpd_pkg::div_req_t           div_req;
    logic [fdpd_pkg::DIV_W-1:0]   div_quo;

    fdpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // registers
    fdpd_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [fdpd_pkg::INT_W-1:0]    max_reg, max_next;
    logic                          ovf_reg, ovf_next;
    logic                          trunc_reg, trunc_next;
    logic [fdpd_pkg::THR_W-1:0]    thr_reg;
    logic [fdpd_pkg::WID_W-1:0]    wid_reg;
    logic                          use_sm_reg, use_sm_next;
    logic [CNT_W-1:0]              i_reg, i_next;
    logic [CNT_W-1:0]              j_reg, j_next;
    logic [CNT_W-1:0]              start_reg, start_next;
    logic [CNT_W-1:0]              apex_reg, apex_next;
    logic [CNT_W-1:0]              stop_reg, stop_next;
    logic [FW-1:0]                 found_reg, found_next;
    logic [FW-1:0]                 k_reg, k_next;
    logic                          m_valid_reg, m_valid_next;
    fdpd_pkg::out_t                m_data_reg, m_data_next;

    logic [fdpd_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [fdpd_pkg::TIME_W-1:0]   tcur_reg, tcur_next;
    logic [fdpd_pkg::TIME_W-1:0]   tprev_reg, tprev_next;
    logic [fdpd_pkg::Y_W-1:0]      yprev_reg, yprev_next;
    logic signed [fdpd_pkg::Y_W:0] dy_reg, dy_next;
    logic signed [32:0]            dx_reg, dx_next;
    logic signed [fdpd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [SW-1:0]          a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [fdpd_pkg::TIME_W-1:0]   ts_reg, ts_next, ta_reg, ta_next;

    // derived values
    logic [fdpd_pkg::WID_W-1:0]    w_sat, w_eff, h_val;
    logic [CNT_W-1:0]              s_val, last_val;
    logic [fdpd_pkg::THR_W-1:0]    thr_eff;
    logic signed [SW:0]            thr_s;
    logic [fdpd_pkg::Y_W-1:0]      y_cur;
    logic [fdpd_pkg::Y_W:0]        dy_mag;
    logic [32:0]                   dx_mag;
    logic signed [fdpd_pkg::SUM_W-1:0] sum_mag;
    logic signed [SW-1:0]          q_signed;
    logic                          interior, start_hit;
    logic [CNT_W:0]                i_plus_h;

    always_comb begin
        w_sat    = (wid_reg > fdpd_pkg::WID_W'(MAX_WIDTH)) ?
                   fdpd_pkg::WID_W'(MAX_WIDTH) : wid_reg;
        w_eff    = (w_sat != '0 && !w_sat[0]) ? w_sat - 1'b1 : w_sat;
        h_val    = w_eff >> 1;
        s_val    = cnt_reg - 1'b1;
        last_val = cnt_reg - CNT_W'(fdpd_pkg::MIN_SAMPLES);
        thr_eff  = (thr_reg == '0) ? fdpd_pkg::DEFAULT_THR : thr_reg;
        thr_s    = $signed({{(SW + 1 - fdpd_pkg::THR_W){1'b0}}, thr_eff});
        sl_q     = use_sm_reg ? sm_q : slope_q;
        y_cur    = (max_reg == '0) ? '0 : div_quo[fdpd_pkg::Y_W-1:0];
        dy_mag   = dy_reg[fdpd_pkg::Y_W] ? 42'(-dy_reg) : 42'(dy_reg);
        dx_mag   = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        sum_mag  = sum_reg[fdpd_pkg::SUM_W-1] ? -sum_reg : sum_reg;
        i_plus_h = {1'b0, i_reg} + (CNT_W + 1)'(h_val);
        interior = (i_reg >= CNT_W'(h_val)) && (i_plus_h < {1'b0, s_val});
        // strictly rising triple above threshold
        start_hit = ((SW + 1)'(a_reg) > thr_s) && ((SW + 1)'(b_reg) > thr_s) &&
                    ((SW + 1)'(c_reg) > thr_s) && (a_reg < b_reg) && (b_reg < c_reg);
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        max_next     = max_reg;
        ovf_next     = ovf_reg;
        trunc_next   = trunc_reg;
        use_sm_next  = use_sm_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        start_next   = start_reg;
        apex_next    = apex_reg;
        stop_next    = stop_reg;
        found_next   = found_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        prod_next    = prod_reg;
        tcur_next    = tcur_reg;
        tprev_next   = tprev_reg;
        yprev_next   = yprev_reg;
        dy_next      = dy_reg;
        dx_next      = dx_reg;
        sum_next     = sum_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        ts_next      = ts_reg;
        ta_next      = ta_reg;
        q_signed     = '0;

        s_ready   = 1'b0;
        samp_we   = 1'b0;
        samp_wa   = cnt_reg[AW-1:0];
        samp_ra   = i_reg[AW-1:0];
        slope_we  = 1'b0;
        slope_wa  = AW'(i_reg - 1'b1);
        slope_wd  = '0;
        slope_ra  = i_reg[AW-1:0];
        sm_we     = 1'b0;
        sm_wa     = i_reg[AW-1:0];
        sm_wd     = slope_q;
        peak_we   = 1'b0;
        peak_wa   = found_reg[PW-1:0];
        peak_wd   = {ts_reg, ta_reg, time_q};
        peak_ra   = k_reg[PW-1:0];
        div_start = 1'b0;
        div_req   = '{rem0: 32'(prod_reg[fdpd_pkg::PROD_W-1:24]),
                      num:  {prod_reg[23:0], 24'd0},
                      den:  max_reg};

        case (state_reg)
            fdpd_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                        samp_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (s_data.intensity > max_reg) max_next = s_data.intensity;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.final_sample) begin
                        trunc_next = ovf_next;
                        i_next     = '0;
                        found_next = '0;
                        use_sm_next = 1'b0;
                        if (cnt_next >= CNT_W'(fdpd_pkg::MIN_SAMPLES))
                            state_next = fdpd_pkg::ST_NRD;
                        else
                            state_next = fdpd_pkg::ST_EMIT;
                    end
                end
            end
            // normalization and slope pass
            fdpd_pkg::ST_NRD: state_next = fdpd_pkg::ST_NMUL;
            fdpd_pkg::ST_NMUL: begin
                prod_next  = fdpd_pkg::PROD_W'(int_q) *
                             fdpd_pkg::PROD_W'(fdpd_pkg::NORM_BASE);
                tcur_next  = time_q;
                state_next = fdpd_pkg::ST_NDIV;
            end
            fdpd_pkg::ST_NDIV: begin
                div_start  = 1'b1;
                state_next = fdpd_pkg::ST_NWAIT;
            end
            fdpd_pkg::ST_NWAIT: begin
                if (div_done) begin
                    yprev_next = y_cur;
                    tprev_next = tcur_reg;
                    if (i_reg == '0) begin
                        i_next     = 1;
                        state_next = fdpd_pkg::ST_NRD;
                    end else begin
                        dy_next = $signed({1'b0, y_cur}) - $signed({1'b0, yprev_reg});
                        dx_next = $signed({1'b0, tcur_reg}) - $signed({1'b0, tprev_reg});
                        state_next = fdpd_pkg::ST_SDIV;
                    end
                end
            end
            fdpd_pkg::ST_SDIV: begin
                div_start  = 1'b1;
                div_req    = '{rem0: '0, num: fdpd_pkg::DIV_W'(dy_mag),
                               den: dx_mag[31:0]};
                state_next = fdpd_pkg::ST_SWAIT;
            end
            fdpd_pkg::ST_SWAIT: begin
                if (div_done) begin
                    q_signed = $signed(div_quo);
                    slope_we = 1'b1;
                    if (dx_reg == '0)
                        slope_wd = '0;
                    else if (dy_reg[fdpd_pkg::Y_W] ^ dx_reg[32])
                        slope_wd = -q_signed;
                    else
                        slope_wd = q_signed;
                    i_next = i_reg + 1'b1;
                    state_next = (i_next == cnt_reg) ? fdpd_pkg::ST_SMSET : fdpd_pkg::ST_NRD;
                end
            end
            // moving average
            fdpd_pkg::ST_SMSET: begin
                i_next   = '0;
                sum_next = '0;
                j_next   = '0;
                if (w_eff != '0 && s_val >= CNT_W'(w_eff)) begin
                    use_sm_next = 1'b1;
                    state_next  = fdpd_pkg::ST_ARD;
                end else begin
                    state_next = fdpd_pkg::ST_SR0;
                end
            end
            fdpd_pkg::ST_ARD: state_next = fdpd_pkg::ST_AADD;
            fdpd_pkg::ST_AADD: begin
                sum_next = sum_reg + fdpd_pkg::SUM_W'(slope_q);
                if (i_reg + 1'b1 == CNT_W'(w_eff)) begin
                    i_next     = '0;
                    state_next = fdpd_pkg::ST_MRD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = fdpd_pkg::ST_ARD;
                end
            end
            fdpd_pkg::ST_MRD: state_next = fdpd_pkg::ST_MCHK;
            fdpd_pkg::ST_MCHK: begin
                if (interior) begin
                    div_start  = 1'b1;
                    div_req    = '{rem0: '0, num: sum_mag[fdpd_pkg::DIV_W-1:0],
                                   den: 32'(w_eff)};
                    state_next = fdpd_pkg::ST_MWAIT;
                end else begin
                    sm_we  = 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = (i_next == s_val) ? fdpd_pkg::ST_SR0 : fdpd_pkg::ST_MRD;
                end
            end
            fdpd_pkg::ST_MWAIT: begin
                if (div_done) begin
                    q_signed = $signed(div_quo);
                    sm_we    = 1'b1;
                    sm_wd    = sum_reg[fdpd_pkg::SUM_W-1] ? -q_signed : q_signed;
                    if (i_plus_h + 1'b1 < {1'b0, s_val}) begin
                        state_next = fdpd_pkg::ST_URD;
                    end else begin
                        i_next = i_reg + 1'b1;
                        state_next = (i_next == s_val) ? fdpd_pkg::ST_SR0 : fdpd_pkg::ST_MRD;
                    end
                end
            end
            // slide window: add the entering slope, drop the leaving one
            fdpd_pkg::ST_URD: begin
                slope_ra   = AW'(i_plus_h + 1'b1);
                state_next = fdpd_pkg::ST_UADD;
            end
            fdpd_pkg::ST_UADD: begin
                sum_next   = sum_reg + fdpd_pkg::SUM_W'(slope_q);
                slope_ra   = AW'(i_reg - CNT_W'(h_val));
                state_next = fdpd_pkg::ST_USUB;
            end
            fdpd_pkg::ST_USUB: begin
                sum_next = sum_reg - fdpd_pkg::SUM_W'(slope_q);
                i_next   = i_reg + 1'b1;
                state_next = (i_next == s_val) ? fdpd_pkg::ST_SR0 : fdpd_pkg::ST_MRD;
            end
            // peak scan
            fdpd_pkg::ST_SR0: begin
                slope_ra   = j_reg[AW-1:0];
                state_next = fdpd_pkg::ST_SR1;
            end
            fdpd_pkg::ST_SR1: begin
                a_next     = sl_q;
                slope_ra   = AW'(j_reg + 1'b1);
                state_next = fdpd_pkg::ST_SR2;
            end
            fdpd_pkg::ST_SR2: begin
                b_next     = sl_q;
                slope_ra   = AW'(j_reg + 2'd2);
                state_next = fdpd_pkg::ST_SR3;
            end
            fdpd_pkg::ST_SR3: begin
                c_next     = sl_q;
                state_next = fdpd_pkg::ST_SCHK;
            end
            fdpd_pkg::ST_SCHK: begin
                if (start_hit) begin
                    start_next = j_reg;
                    state_next = fdpd_pkg::ST_XRD;
                end else if (j_reg == last_val) begin
                    state_next = fdpd_pkg::ST_EMIT;
                end else begin
                    a_next     = b_reg;
                    b_next     = c_reg;
                    slope_ra   = AW'(j_reg + 2'd3);
                    j_next     = j_reg + 1'b1;
                    state_next = fdpd_pkg::ST_SR3;
                end
            end
            fdpd_pkg::ST_XRD: begin
                slope_ra   = j_reg[AW-1:0];
                state_next = fdpd_pkg::ST_XCHK;
            end
            fdpd_pkg::ST_XCHK: begin
                if (sl_q < 0) begin
                    apex_next  = j_reg;
                    state_next = fdpd_pkg::ST_PRD;
                end else if (j_reg == last_val) begin
                    apex_next  = start_reg;
                    j_next     = start_reg;
                    state_next = fdpd_pkg::ST_PRD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = fdpd_pkg::ST_XRD;
                end
            end
            fdpd_pkg::ST_PRD: begin
                slope_ra   = j_reg[AW-1:0];
                state_next = fdpd_pkg::ST_PCHK;
            end
            fdpd_pkg::ST_PCHK: begin
                if (sl_q > 0) begin
                    stop_next  = j_reg;
                    state_next = fdpd_pkg::ST_REC;
                end else if (j_reg == last_val) begin
                    stop_next  = last_val;
                    state_next = fdpd_pkg::ST_REC;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = fdpd_pkg::ST_PRD;
                end
            end
            fdpd_pkg::ST_REC: begin
                if (stop_reg - start_reg >= CNT_W'(fdpd_pkg::MIN_SPAN)) begin
                    if (found_reg == FW'(MAX_PEAKS)) begin
                        trunc_next = 1'b1;
                        state_next = fdpd_pkg::ST_EMIT;
                    end else begin
                        samp_ra    = start_reg[AW-1:0];
                        state_next = fdpd_pkg::ST_T1;
                    end
                end else if (stop_reg == last_val) begin
                    state_next = fdpd_pkg::ST_EMIT;
                end else begin
                    j_next     = stop_reg + 1'b1;
                    state_next = fdpd_pkg::ST_SR0;
                end
            end
            fdpd_pkg::ST_T1: begin
                ts_next    = time_q;
                samp_ra    = apex_reg[AW-1:0];
                state_next = fdpd_pkg::ST_T2;
            end
            fdpd_pkg::ST_T2: begin
                ta_next    = time_q;
                samp_ra    = stop_reg[AW-1:0];
                state_next = fdpd_pkg::ST_T3;
            end
            fdpd_pkg::ST_T3: begin
                peak_we    = 1'b1;
                found_next = found_reg + 1'b1;
                if (stop_reg == last_val) begin
                    state_next = fdpd_pkg::ST_EMIT;
                end else begin
                    j_next     = stop_reg + 1'b1;
                    state_next = fdpd_pkg::ST_SR0;
                end
            end
            // result delivery
            fdpd_pkg::ST_EMIT: begin
                k_next = '0;
                if (found_reg == '0) begin
                    m_data_next  = '{peak_found: 1'b0, start_ms: '0, apex_ms: '0,
                                     stop_ms: '0, run_end: 1'b1, truncated: trunc_reg};
                    m_valid_next = 1'b1;
                    state_next   = fdpd_pkg::ST_EWAIT;
                end else begin
                    state_next = fdpd_pkg::ST_ERD;
                end
            end
            fdpd_pkg::ST_ERD: state_next = fdpd_pkg::ST_ELD;
            fdpd_pkg::ST_ELD: begin
                m_data_next = '{peak_found: 1'b1,
                                start_ms: peak_q[PK_W-1 -: fdpd_pkg::TIME_W],
                                apex_ms:  peak_q[2*fdpd_pkg::TIME_W-1 -: fdpd_pkg::TIME_W],
                                stop_ms:  peak_q[fdpd_pkg::TIME_W-1:0],
                                run_end:  (k_reg + 1'b1 == found_reg),
                                truncated: trunc_reg};
                m_valid_next = 1'b1;
                state_next   = fdpd_pkg::ST_EWAIT;
            end
            fdpd_pkg::ST_EWAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.run_end) begin
                        cnt_next   = '0;
                        max_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = fdpd_pkg::ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = fdpd_pkg::ST_ERD;
                    end
                end
            end
            default: state_next = fdpd_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fdpd_pkg::ST_LOAD;
            cnt_reg     <= '0;
            max_reg     <= '0;
            ovf_reg     <= 1'b0;
            trunc_reg   <= 1'b0;
            use_sm_reg  <= 1'b0;
            found_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= fdpd_pkg::DEFAULT_THR;
            wid_reg     <= fdpd_pkg::DEFAULT_WID;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            max_reg     <= max_next;
            ovf_reg     <= ovf_next;
            trunc_reg   <= trunc_next;
            use_sm_reg  <= use_sm_next;
            found_reg   <= found_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == fdpd_pkg::REG_THRESHOLD)
                thr_reg <= cfg_wdata;
            if (cfg_we && cfg_index == fdpd_pkg::REG_SMOOTH)
                wid_reg <= cfg_wdata[fdpd_pkg::WID_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        start_reg  <= start_next;
        apex_reg   <= apex_next;
        stop_reg   <= stop_next;
        m_data_reg <= m_data_next;
        prod_reg   <= prod_next;
        tcur_reg   <= tcur_next;
        tprev_reg  <= tprev_next;
        yprev_reg  <= yprev_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        sum_reg    <= sum_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        ts_reg     <= ts_next;
        ta_reg     <= ta_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire
